// ===== hdl/lpsa_pkg.sv =====
// Shared types and constants for the lidar packet sync and sector average block.
package lpsa_pkg;

    // Packet framing.
    localparam int PACKET_BYTES = 7;
    localparam int WIN_IDX_BITS = $clog2(PACKET_BYTES);
    localparam int FILL_BITS    = $clog2(PACKET_BYTES + 1);
    localparam int CHK_BITS     = 11;
    localparam logic [8:0] MOD_BASE = 9'd255;

    // Accumulator and average widths.
    localparam int SUM_BITS  = 32;
    localparam int FRAC_BITS = 8;
    localparam int DVD_BITS  = SUM_BITS + FRAC_BITS;
    localparam int AVG_BITS  = 24;
    localparam int STEP_BITS = $clog2(DVD_BITS + 1);

    // Configuration registers and their reset values.
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_DATA_BITS-1:0] SECTOR_LOW_RST  = 16'd48;
    localparam logic [CFG_DATA_BITS-1:0] SECTOR_HIGH_RST = 16'd5728;

    typedef enum logic [0:0] {
        CFG_SECTOR_LOW  = 1'b0,
        CFG_SECTOR_HIGH = 1'b1
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval;
        logic div_take;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pkt_ok;
        logic div_need;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== hdl/lpsa_ctrl.sv =====
// Controller state machine that sequences byte intake, evaluation, division and output.
module lpsa_ctrl
    import lpsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  t_dp_status i_status,
    input  logic       i_div_done,
    output t_dp_cmd    o_cmd,
    output logic       o_div_start
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_div_start = 1'b0;
        o_rx_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_rx_stall   = 1'b0;
                o_cmd.accept = i_rx_valid;
                if (i_rx_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_status.pkt_ok) begin
                    n_state = ST_IDLE;
                end else if (i_status.div_need) begin
                    o_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lpsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sector average.
module lpsa_div
    import lpsa_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_BITS-1:0]   i_sum,
    input  logic [COUNT_BITS-1:0] i_count,
    output logic                  o_done,
    output logic [AVG_BITS-1:0]   o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [DVD_BITS-1:0]   r_dvd;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvs;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  q_bit;
    logic [COUNT_BITS:0]   rem_sub;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_BITS-1]};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_BITS'(DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts left while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_sum, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_dvs <= i_count;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], q_bit};
            r_rem <= rem_sub[COUNT_BITS-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd[AVG_BITS-1:0];

endmodule

// ===== hdl/lpsa_dp.sv =====
// Datapath: byte window, checksum test, sector accumulators, config and output register.
module lpsa_dp
    import lpsa_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic [7:0]               i_rx_byte,
    input  logic                     i_out_stall,
    output logic [SUM_BITS-1:0]      o_sum,
    output logic [COUNT_BITS-1:0]    o_count,
    input  logic [AVG_BITS-1:0]      i_quotient,
    output logic                     o_out_valid,
    output logic [15:0]              o_azimuth_raw,
    output logic [15:0]              o_distance_cm,
    output logic [7:0]               o_signal_strength,
    output logic [7:0]               o_status_byte,
    output logic                     o_in_sector,
    output logic                     o_average_valid,
    output logic [AVG_BITS-1:0]      o_average_q8
);

    logic [7:0]               r_win [PACKET_BYTES];
    logic [FILL_BITS-1:0]     r_fill;
    logic [SUM_BITS-1:0]      r_sum;
    logic [COUNT_BITS-1:0]    r_count;
    logic                     r_pending;
    logic [CFG_DATA_BITS-1:0] r_sector_low;
    logic [CFG_DATA_BITS-1:0] r_sector_high;

    // Packet held between evaluation and output.
    logic [15:0]         r_h_az;
    logic [15:0]         r_h_dist;
    logic [7:0]          r_h_sig;
    logic [7:0]          r_h_stat;
    logic                r_h_in;
    logic                r_h_avg_valid;
    logic [AVG_BITS-1:0] r_h_avg;

    logic                r_out_valid;

    logic [CHK_BITS-1:0] chk_sum;
    logic [8:0]          chk_fold;
    logic [8:0]          chk_mod;
    logic                win_full;
    logic                pkt_ok;
    logic [15:0]         az;
    logic [15:0]         pkt_dist;
    logic                in_sec;
    logic                leave;
    logic [SUM_BITS:0]   sum_add;
    logic                can_add;
    logic                count_zero;

    // Checksum over the first six bytes; 256 folds to 1 modulo 255.
    always_comb begin
        chk_sum = '0;
        for (int k = 0; k < PACKET_BYTES - 1; k++) begin
            chk_sum = chk_sum + CHK_BITS'(r_win[k]);
        end
        chk_fold = {1'b0, chk_sum[7:0]} + 9'(chk_sum[CHK_BITS-1:8]);
        chk_mod  = (chk_fold >= MOD_BASE) ? (chk_fold - MOD_BASE) : chk_fold;
        win_full = (r_fill == FILL_BITS'(PACKET_BYTES));
        pkt_ok   = win_full && (chk_mod == {1'b0, r_win[PACKET_BYTES-1]});
    end

    // Packet fields and sector decisions.
    always_comb begin
        az         = {r_win[2], r_win[1]};
        pkt_dist   = {r_win[4], r_win[3]};
        in_sec     = (az < r_sector_low) || (az > r_sector_high);
        leave      = !in_sec && r_pending;
        sum_add    = {1'b0, r_sum} + (SUM_BITS + 1)'(pkt_dist);
        can_add    = (r_count != {COUNT_BITS{1'b1}}) && !sum_add[SUM_BITS];
        count_zero = (r_count == '0);
    end

    assign o_status.pkt_ok   = pkt_ok;
    assign o_status.div_need = pkt_ok && leave && !count_zero;
    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_sum   = r_sum;
    assign o_count = r_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_low  <= SECTOR_LOW_RST;
            r_sector_high <= SECTOR_HIGH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SECTOR_LOW:  r_sector_low  <= i_cfg_data;
                CFG_SECTOR_HIGH: r_sector_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window fill level; a valid packet empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.accept && !win_full) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.eval && pkt_ok) begin
            r_fill <= '0;
        end
    end

    // Window contents: append until full, then slide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (!win_full) begin
                r_win[r_fill[WIN_IDX_BITS-1:0]] <= i_rx_byte;
            end else begin
                for (int k = 0; k < PACKET_BYTES - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[PACKET_BYTES-1] <= i_rx_byte;
            end
        end
    end

    // Sector accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_pending <= 1'b0;
        end else if (i_cmd.eval && pkt_ok) begin
            if (in_sec) begin
                if (can_add) begin
                    r_sum   <= sum_add[SUM_BITS-1:0];
                    r_count <= r_count + 1'b1;
                end
                r_pending <= 1'b1;
            end else if (r_pending) begin
                r_sum     <= '0;
                r_count   <= '0;
                r_pending <= 1'b0;
            end
        end
    end

    // Hold register for the packet under way.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && pkt_ok) begin
            r_h_az        <= az;
            r_h_dist      <= pkt_dist;
            r_h_sig       <= r_win[5];
            r_h_stat      <= r_win[0];
            r_h_in        <= in_sec;
            r_h_avg_valid <= leave;
            r_h_avg       <= '0;
        end else if (i_cmd.div_take) begin
            r_h_avg <= i_quotient;
        end
    end

    // Output beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_azimuth_raw     <= r_h_az;
            o_distance_cm     <= r_h_dist;
            o_signal_strength <= r_h_sig;
            o_status_byte     <= r_h_stat;
            o_in_sector       <= r_h_in;
            o_average_valid   <= r_h_avg_valid;
            o_average_q8      <= r_h_avg;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/lidar_packet_sync_sector_average.sv =====
// Top level of the lidar packet sync and forward-sector distance average block.
//
// Input channel: one received byte per beat on i_rx_byte, i_rx_valid / o_rx_stall.
// Output channel: one beat per packet that passes its checksum, o_out_valid /
// i_out_stall, carrying azimuth, distance, signal, status, the sector flag and,
// on leaving the sector, the mean sector distance with 8 fraction bits.
// Configuration: i_cfg_we writes i_cfg_data to sector_low (index 0) or
// sector_high (index 1). Writes must come only while the block is idle; the block
// itself does not enforce this. Sequencing: each byte is accepted in the idle
// state and tested in the evaluation state, so input stalls between bytes, and a
// byte that completes a good packet loads its beat in the emit state. A packet
// that closes a sector run first runs the restoring divider, one quotient bit per
// cycle over 40 bits, before its beat is loaded.
// The output register lets the next byte be taken while a beat waits; when the
// receiver stalls, the next packet waits in its hold register and input stops.
// Reset clears the window fill level, accumulators, state and output valid,
// and returns the sector bounds to 48 and 5728. No clearing pass is needed.
module lidar_packet_sync_sector_average
    import lpsa_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_rx_valid,
    output logic                     o_rx_stall,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [15:0]              o_azimuth_raw,
    output logic [15:0]              o_distance_cm,
    output logic [7:0]               o_signal_strength,
    output logic [7:0]               o_status_byte,
    output logic                     o_in_sector,
    output logic                     o_average_valid,
    output logic [AVG_BITS-1:0]      o_average_q8
);

    t_dp_cmd               cmd;
    t_dp_status            status;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic [AVG_BITS-1:0]   quotient;

    lpsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_status    (status),
        .i_div_done  (div_done),
        .o_cmd       (cmd),
        .o_div_start (div_start)
    );

    lpsa_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_rx_byte         (i_rx_byte),
        .i_out_stall       (i_out_stall),
        .o_sum             (sum),
        .o_count           (count),
        .i_quotient        (quotient),
        .o_out_valid       (o_out_valid),
        .o_azimuth_raw     (o_azimuth_raw),
        .o_distance_cm     (o_distance_cm),
        .o_signal_strength (o_signal_strength),
        .o_status_byte     (o_status_byte),
        .o_in_sector       (o_in_sector),
        .o_average_valid   (o_average_valid),
        .o_average_q8      (o_average_q8)
    );

    lpsa_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_sum      (sum),
        .i_count    (count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

endmodule

// ===== hdl/lpsa_chk.sv =====
// Port-level checker for the lidar packet sync block, with its bind statement.
module lpsa_chk
    import lpsa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_rx_valid,
    input logic                o_rx_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [15:0]         o_azimuth_raw,
    input logic [15:0]         o_distance_cm,
    input logic                o_in_sector,
    input logic                o_average_valid,
    input logic [AVG_BITS-1:0] o_average_q8
);

    // An accepted byte is tested before the next byte is taken.
    a_accept_then_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx_valid && !o_rx_stall) |=> o_rx_stall)
        else $error("input taken in the cycle after an accepted byte");

    // Without an average the average field reads zero.
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_average_valid) |-> (o_average_q8 == '0))
        else $error("average field nonzero without average flag");

    // An average is only reported by a packet outside the sector.
    a_avg_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_average_valid) |-> !o_in_sector)
        else $error("average reported on an in-sector packet");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_azimuth_raw) && $stable(o_distance_cm)
             && $stable(o_average_q8)))
        else $error("stalled output beat changed");

endmodule

bind lidar_packet_sync_sector_average lpsa_chk u_lpsa_chk (.*);

// ===== tb/lidar_packet_sync_sector_average_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the lidar packet sync and forward-sector average block.
module lidar_packet_sync_sector_average_tb;
    import lpsa_pkg::*;

    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
    localparam int DRAIN_CYCLES = 100;

    // One packet beat as the block reports it.
    typedef struct packed {
        logic [15:0]         azimuth;
        logic [15:0]         distance;
        logic [7:0]          signal_strength;
        logic [7:0]          status;
        logic                in_sector;
        logic                avg_valid;
        logic [AVG_BITS-1:0] avg_q8;
    } t_pkt_beat;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    t_cfg_idx                 cfg_idx = CFG_SECTOR_LOW;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     rx_valid = 1'b0;
    logic                     rx_stall;
    logic [7:0]               rx_byte = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [15:0]              azimuth_raw;
    logic [15:0]              distance_cm;
    logic [7:0]               signal_strength;
    logic [7:0]               status_byte;
    logic                     in_sector;
    logic                     average_valid;
    logic [AVG_BITS-1:0]      average_q8;

    // Stimulus queue, predicted beats and run control.
    logic [7:0] rx_byte_q[$];
    t_pkt_beat  predicted_pkts[$];
    t_pkt_beat  oldest_pkt;
    int         bytes_queued = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         err_cnt = 0;
    bit         rx_taken;
    int         sector_run_left = 0;
    bit         sector_want_in = 1'b0;

    // Predictor state: packet window, sector accumulators and bounds.
    logic [7:0]          win[PACKET_BYTES];
    int                  win_fill = 0;
    logic [SUM_BITS-1:0] fwd_sum = '0;
    logic [CNT_BITS-1:0] fwd_count = '0;
    bit                  avg_pending = 1'b0;
    logic [15:0]         fwd_lo = SECTOR_LOW_RST;
    logic [15:0]         fwd_hi = SECTOR_HIGH_RST;

    lidar_packet_sync_sector_average #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .o_rx_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_azimuth_raw    (azimuth_raw),
        .o_distance_cm    (distance_cm),
        .o_signal_strength(signal_strength),
        .o_status_byte    (status_byte),
        .o_in_sector      (in_sector),
        .o_average_valid  (average_valid),
        .o_average_q8     (average_q8)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The sector wraps around zero: below the low bound or above the high bound.
    function automatic bit in_fwd_sector(logic [15:0] az);
        return (az < fwd_lo) || (az > fwd_hi);
    endfunction

    // Shift one byte into the window; a full window with a good checksum yields a beat.
    function automatic void absorb_rx_byte(logic [7:0] b);
        logic [10:0]         acc;
        logic [DVD_BITS-1:0] quot;
        t_pkt_beat           beat;
        int                  k;
        if (win_fill < PACKET_BYTES) begin
            win[win_fill] = b;
            win_fill++;
        end else begin
            for (k = 0; k < PACKET_BYTES - 1; k++)
                win[k] = win[k + 1];
            win[PACKET_BYTES - 1] = b;
        end
        if (win_fill < PACKET_BYTES)
            return;
        acc = '0;
        for (k = 0; k < PACKET_BYTES - 1; k++)
            acc += win[k];
        if ((acc % 11'd255) != {3'b000, win[PACKET_BYTES - 1]})
            return;

        win_fill = 0;
        beat = '0;
        beat.azimuth         = {win[2], win[1]};
        beat.distance        = {win[4], win[3]};
        beat.signal_strength = win[5];
        beat.status          = win[0];
        beat.in_sector       = in_fwd_sector(beat.azimuth);

        // Accumulate inside the sector; report and clear on the way out.
        if (beat.in_sector) begin
            if (fwd_count < CNT_MAX && ({1'b0, fwd_sum} + beat.distance) <= 33'h0_FFFF_FFFF) begin
                fwd_sum   = fwd_sum + beat.distance;
                fwd_count = fwd_count + 1'b1;
            end
            avg_pending = 1'b1;
        end else if (avg_pending) begin
            beat.avg_valid = 1'b1;
            if (fwd_count != 0) begin
                quot = {fwd_sum, {FRAC_BITS{1'b0}}} / fwd_count;
                beat.avg_q8 = quot[AVG_BITS-1:0];
            end
            fwd_sum     = '0;
            fwd_count   = '0;
            avg_pending = 1'b0;
        end
        predicted_pkts.push_back(beat);
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_cnt++;
        end
    endtask

    // Driver: present queued bytes, idling at random between beats.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
            rx_byte  <= '0;
        end else begin
            rx_taken = rx_valid && !rx_stall;
            if (rx_taken)
                absorb_rx_byte(rx_byte);
            if (!rx_valid || rx_taken) begin
                if (rx_byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_byte_q.pop_front();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted packet beat with the oldest prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (predicted_pkts.size() == 0) begin
                    $error("unexpected packet beat, azimuth %0d", azimuth_raw);
                    err_cnt++;
                end else begin
                    oldest_pkt = predicted_pkts.pop_front();
                    check_field("azimuth_raw", oldest_pkt.azimuth, azimuth_raw);
                    check_field("distance_cm", oldest_pkt.distance, distance_cm);
                    check_field("signal_strength", oldest_pkt.signal_strength,
                                signal_strength);
                    check_field("status_byte", oldest_pkt.status, status_byte);
                    check_field("in_sector", oldest_pkt.in_sector, in_sector);
                    check_field("average_valid", oldest_pkt.avg_valid, average_valid);
                    check_field("average_q8", oldest_pkt.avg_q8, average_q8);
                end
            end
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic push_rx(logic [7:0] b);
        rx_byte_q.push_back(b);
        bytes_queued++;
    endtask

    // Queue one 7-byte packet; a broken one gets a wrong or impossible checksum.
    task automatic push_packet(logic [7:0] status, logic [15:0] az, logic [15:0] dist_val,
                               logic [7:0] sig, bit broken);
        logic [10:0] acc;
        logic [7:0]  chk;
        acc = status + az[7:0] + az[15:8] + dist_val[7:0] + dist_val[15:8] + sig;
        chk = 8'(acc % 11'd255);
        if (broken)
            chk = $urandom_range(1) ? 8'hFF : chk + 8'd1;
        push_rx(status);
        push_rx(az[7:0]);
        push_rx(az[15:8]);
        push_rx(dist_val[7:0]);
        push_rx(dist_val[15:8]);
        push_rx(sig);
        push_rx(chk);
    endtask

    // Azimuth on the wanted side of the sector where the bounds allow it, edges now and then.
    function automatic logic [15:0] pick_azimuth(bit want_in);
        logic [15:0] az;
        int          tries;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       az = fwd_lo - 16'd1;
                1:       az = fwd_lo;
                2:       az = fwd_hi;
                default: az = fwd_hi + 16'd1;
            endcase
            return az;
        end
        for (tries = 0; tries < 16; tries++) begin
            az = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(5759));
            if (in_fwd_sector(az) == want_in)
                break;
        end
        return az;
    endfunction

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(255));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Mostly packets in sector runs then exits, with broken packets and line noise.
    task automatic queue_random(int n);
        int goal;
        int pick;
        goal = bytes_queued + n;
        while (bytes_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 6))
                    push_rx(8'($urandom_range(255)));
            end else begin
                if (sector_run_left == 0) begin
                    sector_want_in  = !sector_want_in;
                    sector_run_left = sector_want_in ? $urandom_range(1, 8) : $urandom_range(1, 3);
                end
                sector_run_left--;
                push_packet(8'($urandom_range(255)), pick_azimuth(sector_want_in),
                            pick_distance(), 8'($urandom_range(255)), pick < 30);
            end
        end
    endtask

    // Wait until every byte is taken and every predicted beat has arrived.
    task automatic wait_quiet();
        while (rx_byte_q.size() != 0 || rx_valid || predicted_pkts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SECTOR_LOW)
            fwd_lo = val;
        else
            fwd_hi = val;
    endtask

    task automatic run_phase(logic [15:0] lo, logic [15:0] hi, int tx_pct, int rx_pct, int n);
        wait_quiet();
        write_reg(CFG_SECTOR_LOW, lo);
        write_reg(CFG_SECTOR_HIGH, hi);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        queue_random(n);
    endtask

    // Main sequence: reset, directed packets, then random phases over several bound settings.
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct  = 21;
        rx_stall_pct = 86;

        // All-ones and all-zero packets enter the sector, a boundary azimuth leaves it.
        push_packet(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        push_packet(8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        push_packet(8'h01, SECTOR_LOW_RST, 16'd1234, 8'h80, 1'b0);
        queue_random(280);

        // Empty sector, full sector, a narrow out-of-sector gap, inverted bounds, then defaults again.
        run_phase(16'h0000, 16'hFFFF, 21, 86, 100);
        run_phase(16'hFFFF, 16'h0000, 86, 21, 100);
        run_phase(16'd2000, 16'd4000, 86, 21, 270);
        run_phase(16'd30000, 16'd1000, 0, 0, 150);
        run_phase(SECTOR_LOW_RST, SECTOR_HIGH_RST, 0, 0, 230);
        wait_quiet();

        if (err_cnt == 0) begin
            $display("lidar_packet_sync_sector_average_tb: clean");
        end else begin
            $display("lidar_packet_sync_sector_average_tb: errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("lidar_packet_sync_sector_average_tb: errors");
        $finish;
    end

endmodule
